// ----- hw/rtl/moving_average_filter_core_defines.svh -----
// ----------------------------------------------------------------------------
// Moving average filter core: assertion macros
// Shared concurrent assertion helpers, clocked on aclk, quiet during reset.
// ----------------------------------------------------------------------------
`ifndef MOVING_AVERAGE_FILTER_CORE_DEFINES_SVH
`define MOVING_AVERAGE_FILTER_CORE_DEFINES_SVH

// Same-cycle implication.
`define MAVG_ASSERT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define MAVG_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/mavg_pkg.sv -----
// ----------------------------------------------------------------------------
// Moving average filter package
// Sequencer states and register constants.
// ----------------------------------------------------------------------------
`default_nettype none

package mavg_pkg;

    localparam int CFG_W = 7;
    localparam logic [CFG_W-1:0] LEN_RESET = 7'd16;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DROP,
        ST_WRITE,
        ST_SCAN,
        ST_START,
        ST_DIV,
        ST_OUT
    } mavg_state_t;

endpackage

`default_nettype wire

// ----- hw/rtl/mavg_ram.sv -----
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module mavg_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// ----- hw/rtl/mavg_div.sv -----
// ----------------------------------------------------------------------------
// Bit-serial unsigned divider
// Restoring division, one quotient bit per cycle, MSB first.
// ----------------------------------------------------------------------------
`default_nettype none

module mavg_div #(
    parameter int DIVIDEND_W = 23,
    parameter int DIVISOR_W  = 7
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  start,
    input  wire logic [DIVIDEND_W-1:0] dividend,
    input  wire logic [DIVISOR_W-1:0]  divisor,
    output logic                       done,
    output logic      [DIVIDEND_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [DIVIDEND_W-1:0] dq_reg, dq_next;
    logic [DIVISOR_W-1:0]  dvs_reg, dvs_next;

    logic [DIVISOR_W:0]    trial;
    logic [DIVISOR_W:0]    diff;
    logic                  fits;

    // trial remainder with the next dividend bit shifted in
    assign trial = {rem_reg, dq_reg[DIVIDEND_W-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign fits  = (trial >= {1'b0, dvs_reg});

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dq_next   = dq_reg;
        dvs_next  = dvs_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DIVIDEND_W);
            rem_next  = '0;
            dq_next   = dividend;
            dvs_next  = divisor;
        end else if (busy_reg) begin
            rem_next = fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
            dq_next  = {dq_reg[DIVIDEND_W-2:0], fits};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        dq_reg  <= dq_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = dq_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/moving_average_filter_core.sv -----
// Per beat: the sample is registered while idle, the running sum is updated, the bit-serial
// divider runs, and the result is registered onto m_tvalid once the result slot is free; no
// new beat is taken until then. After a window_len write the next beat also rescans the
// history from RAM, one entry a cycle, over L entries, L being window_len held to 1..WINDOW_MAX.
// Reset (aresetn low, synchronous): history reads as zeros, sum zero, window_len 16,
// no result pending.
// ----------------------------------------------------------------------------
// Moving average filter core
// Running-sum moving average over a circular sample history in RAM, with a
// bit-serial divide by the window length, truncating toward zero.
// ----------------------------------------------------------------------------
`default_nettype none

`include "moving_average_filter_core_defines.svh"

module moving_average_filter_core #(
    parameter int WINDOW_MAX   = 64,
    parameter int SAMPLE_WIDTH = 16,
    localparam int TDATA_W = ((SAMPLE_WIDTH + 7) / 8) * 8
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    // input stream
    input  wire logic                       s_tvalid,
    output logic                            s_tready,
    input  wire logic [TDATA_W-1:0]         s_tdata,   // sample
    // result stream
    output logic                            m_tvalid,
    input  wire logic                       m_tready,
    output logic      [TDATA_W-1:0]         m_tdata,   // average
    // window_len register
    input  wire logic                       cfg_wr_en,
    input  wire logic [mavg_pkg::CFG_W-1:0] cfg_wr_data
);

    import mavg_pkg::*;

    localparam int AW    = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int CW    = $clog2(WINDOW_MAX + 1);      // holds 0..WINDOW_MAX
    localparam int PW    = $clog2(2 * WINDOW_MAX + 1);  // address arithmetic
    localparam int SUM_W = SAMPLE_WIDTH + CW;

    // ------------------------------------------------------------------------
    // State
    // ------------------------------------------------------------------------
    mavg_state_t              state_reg, state_next;
    logic [CFG_W-1:0]         len_reg, len_next;
    logic                     dirty_reg, dirty_next;       // sum stale after len write
    logic [SUM_W-1:0]         sum_reg, sum_next;
    logic [SAMPLE_WIDTH-1:0]  sample_reg, sample_next;
    logic [AW-1:0]            wptr_reg, wptr_next;         // next slot to write
    logic [CW-1:0]            count_reg, count_next;       // entries written, saturating
    logic                     drop_vld_reg, drop_vld_next;
    logic [CW-1:0]            idx_reg, idx_next;           // scan position, newest first
    logic                     acc_pend_reg, acc_pend_next;
    logic                     acc_vld_reg, acc_vld_next;
    logic                     neg_reg, neg_next;
    logic                     m_valid_reg, m_valid_next;
    logic [SAMPLE_WIDTH-1:0]  m_data_reg, m_data_next;

    // ------------------------------------------------------------------------
    // Effective window length: zero acts as one, saturate at capacity
    // ------------------------------------------------------------------------
    logic [CW-1:0] eff_len;

    always_comb begin
        if (len_reg == '0) begin
            eff_len = CW'(1);
        end else if ({1'b0, len_reg} > 8'(WINDOW_MAX)) begin
            eff_len = CW'(WINDOW_MAX);
        end else begin
            eff_len = CW'(len_reg);
        end
    end

    // ------------------------------------------------------------------------
    // History RAM. Entry k back from the newest sits at wptr-1-k (mod depth).
    // While idle the read port points at the entry about to leave the window.
    // ------------------------------------------------------------------------
    logic [CW-1:0]           rd_off;
    logic [PW-1:0]           addr_tmp;
    logic [AW-1:0]           rd_addr;
    logic [SAMPLE_WIDTH-1:0] rd_data;
    logic                    ram_we;
    logic [SUM_W-1:0]        rd_ext;
    logic [SUM_W-1:0]        sample_ext;

    assign rd_off   = (state_reg == ST_IDLE) ? eff_len : (idx_reg + CW'(1));
    assign addr_tmp = PW'(wptr_reg) + PW'(WINDOW_MAX) - PW'(rd_off);
    assign rd_addr  = (addr_tmp >= PW'(WINDOW_MAX)) ? AW'(addr_tmp - PW'(WINDOW_MAX))
                                                    : AW'(addr_tmp);
    assign ram_we   = (state_reg == ST_DROP) || (state_reg == ST_WRITE);

    assign rd_ext     = {{CW{rd_data[SAMPLE_WIDTH-1]}}, rd_data};
    assign sample_ext = {{CW{sample_reg[SAMPLE_WIDTH-1]}}, sample_reg};

    mavg_ram #(
        .WIDTH (SAMPLE_WIDTH),
        .DEPTH (WINDOW_MAX)
    ) u_hist (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (wptr_reg),
        .wr_data (sample_reg),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // ------------------------------------------------------------------------
    // Divider: |sum| / eff_len, sign restored afterwards (truncation to zero)
    // ------------------------------------------------------------------------
    logic             div_start;
    logic             div_done;
    logic [SUM_W-1:0] div_dividend;
    logic [SUM_W-1:0] div_quot;
    logic [SAMPLE_WIDTH-1:0] quot_trunc;

    assign div_dividend = sum_reg[SUM_W-1] ? (~sum_reg + SUM_W'(1)) : sum_reg;
    assign quot_trunc   = div_quot[SAMPLE_WIDTH-1:0];

    mavg_div #(
        .DIVIDEND_W (SUM_W),
        .DIVISOR_W  (CW)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (eff_len),
        .done     (div_done),
        .quotient (div_quot)
    );

    // ------------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------------
    always_comb begin
        state_next    = state_reg;
        len_next      = len_reg;
        dirty_next    = dirty_reg;
        sum_next      = sum_reg;
        sample_next   = sample_reg;
        wptr_next     = wptr_reg;
        count_next    = count_reg;
        drop_vld_next = drop_vld_reg;
        idx_next      = idx_reg;
        acc_pend_next = acc_pend_reg;
        acc_vld_next  = acc_vld_reg;
        neg_next      = neg_reg;
        m_valid_next  = m_valid_reg;
        m_data_next   = m_data_reg;
        s_tready      = 1'b0;
        div_start     = 1'b0;

        // result slot drains independently
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    sample_next   = s_tdata[SAMPLE_WIDTH-1:0];
                    // leaving entry only counts if it was ever written
                    drop_vld_next = (eff_len <= count_reg);
                    state_next    = dirty_reg ? ST_WRITE : ST_DROP;
                end
            end
            ST_DROP: begin
                // running update: add newest, remove the one falling out
                sum_next   = sum_reg + sample_ext - (drop_vld_reg ? rd_ext : '0);
                wptr_next  = (wptr_reg == AW'(WINDOW_MAX - 1)) ? '0 : wptr_reg + AW'(1);
                count_next = (count_reg == CW'(WINDOW_MAX)) ? count_reg
                                                            : count_reg + CW'(1);
                state_next = ST_START;
            end
            ST_WRITE: begin
                wptr_next     = (wptr_reg == AW'(WINDOW_MAX - 1)) ? '0 : wptr_reg + AW'(1);
                count_next    = (count_reg == CW'(WINDOW_MAX)) ? count_reg
                                                               : count_reg + CW'(1);
                sum_next      = '0;
                idx_next      = '0;
                acc_pend_next = 1'b0;
                state_next    = ST_SCAN;
            end
            ST_SCAN: begin
                // read issued this cycle, summed the next
                if (acc_pend_reg) begin
                    sum_next = sum_reg + (acc_vld_reg ? rd_ext : '0);
                end
                if (idx_reg < eff_len) begin
                    acc_pend_next = 1'b1;
                    acc_vld_next  = (idx_reg < count_reg);
                    idx_next      = idx_reg + CW'(1);
                end else begin
                    acc_pend_next = 1'b0;
                    if (!acc_pend_reg) begin
                        dirty_next = 1'b0;
                        state_next = ST_START;
                    end
                end
            end
            ST_START: begin
                div_start  = 1'b1;
                neg_next   = sum_reg[SUM_W-1];
                state_next = ST_DIV;
            end
            ST_DIV: begin
                if (div_done) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = neg_reg ? ('0 - quot_trunc) : quot_trunc;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // register write, only while idle: a rule for the user, the block itself does not enforce it
        if (cfg_wr_en) begin
            len_next   = cfg_wr_data;
            dirty_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            len_reg      <= LEN_RESET;
            dirty_reg    <= 1'b0;
            sum_reg      <= '0;
            wptr_reg     <= '0;
            count_reg    <= '0;
            acc_pend_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            len_reg      <= len_next;
            dirty_reg    <= dirty_next;
            sum_reg      <= sum_next;
            wptr_reg     <= wptr_next;
            count_reg    <= count_next;
            acc_pend_reg <= acc_pend_next;
            m_valid_reg  <= m_valid_next;
        end
        sample_reg   <= sample_next;
        drop_vld_reg <= drop_vld_next;
        idx_reg      <= idx_next;
        acc_vld_reg  <= acc_vld_next;
        neg_reg      <= neg_next;
        m_data_reg   <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = TDATA_W'(m_data_reg);

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    `MAVG_ASSERT_NEXT(a_one_beat_at_a_time, s_tvalid && s_tready, !s_tready, "beat while busy")
    `MAVG_ASSERT(a_fill_bound, 1'b1, count_reg <= CW'(WINDOW_MAX), "fill count past capacity")
    `MAVG_ASSERT(a_div_done_state, div_done, state_reg == ST_DIV, "divider done outside divide")
    `MAVG_ASSERT(a_len_range, 1'b1, eff_len != '0 && eff_len <= CW'(WINDOW_MAX), "bad window length")

endmodule

`default_nettype wire
